>>> hw/rtl/rrsvm_pkg.sv
// Shared types and constants for the round-robin sample voice mixer.
// Holds the fixed sizes of the voice and slot tables and the scaling unit's interface.
// Depends on nothing.
package rrsvm_pkg;

  localparam int unsigned VOICES     = 8;
  localparam int unsigned SLOTS      = 32;
  localparam int unsigned VOICE_W    = 3;
  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned LEN_W      = 17;
  localparam int unsigned CNT_W      = 4;

  localparam logic [7:0]        VOLUME_FULL = 8'd255;
  localparam logic [LEN_W-1:0]  MAX_LENGTH  = 17'd65536;

  // Signed sum of all voices: each voice adds at most 32768 in magnitude.
  localparam int unsigned SUM_W      = 20;

  // Scaling unit: q = floor(a * b / 255).
  localparam int unsigned SCL_A_W     = 20;
  localparam int unsigned SCL_B_W     = 8;
  localparam int unsigned SCL_PROD_W  = SCL_A_W + SCL_B_W;
  localparam int unsigned SCL_Q_W     = 21;
  localparam int unsigned SCL_RECIP_W = 24;
  localparam int unsigned SCL_SHIFT   = 31;
  // floor(2^31 / 255); the estimate it gives is at most one below the quotient.
  localparam logic [SCL_RECIP_W-1:0] SCL_RECIP = 24'd8421504;

  typedef struct packed {
    logic               start;
    logic [SCL_A_W-1:0] a;
    logic [SCL_B_W-1:0] b;
  } scl_req_t;

  typedef struct packed {
    logic               done;
    logic [SCL_Q_W-1:0] q;
  } scl_rsp_t;

endpackage

>>> hw/rtl/rrsvm_scale.sv
// Shared scaling unit: floor(a * b / 255) in three pipelined steps.
// A product, a reciprocal estimate and one correction step.
// Depends on rrsvm_pkg.
module rrsvm_scale import rrsvm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  scl_req_t req_i,
  output scl_rsp_t rsp_o
);

  localparam int unsigned WideW = SCL_PROD_W + SCL_RECIP_W;
  localparam int unsigned BackW = SCL_Q_W + 8;

  logic                  s1_q, s2_q, done_q;
  logic [SCL_PROD_W-1:0] prod_q, prod2_q;
  logic [SCL_Q_W-1:0]    q0_q, q_q;
  logic [WideW-1:0]      wide;
  logic [BackW-1:0]      back;
  logic [BackW-1:0]      rem;
  logic [SCL_Q_W-1:0]    q_d;

  assign wide = {{SCL_RECIP_W{1'b0}}, prod_q} * {{SCL_PROD_W{1'b0}}, SCL_RECIP};

  // back = q0 * 255, written as a shift and a subtract.
  assign back = {q0_q, 8'b0} - {8'b0, q0_q};
  assign rem  = {{(BackW-SCL_PROD_W){1'b0}}, prod2_q} - back;
  assign q_d  = (rem >= BackW'(VOLUME_FULL)) ? q0_q + SCL_Q_W'(1) : q0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= req_i.start;
      s2_q   <= s1_q;
      done_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= {{SCL_B_W{1'b0}}, req_i.a} * {{SCL_A_W{1'b0}}, req_i.b};
    prod2_q <= prod_q;
    q0_q    <= wide[SCL_SHIFT +: SCL_Q_W];
    q_q     <= q_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = q_q;

endmodule

>>> hw/rtl/round_robin_sample_voice_mixer_core.sv
// Top level of the round-robin sample voice mixer: sequencer, voice and slot
// tables, sample memory and output register. Depends on rrsvm_pkg and rrsvm_scale.
//
//   channel  direction  handshake                   payload
//   input    in         in_valid_i / in_stall_o     op_i .. byte_value_i
//   result   out        out_valid_o / out_stall_i   audio_out_o .. status_o
//   config   in         cfg_we_i                    cfg_addr_i, cfg_wdata_i
//
// A tick visits the eight voices in turn: an idle voice takes only the slot check, an
// active one also takes the scaling start and then waits on the shared scaling unit;
// master volume is then scaled on that unit too, unless muted. A tick's result and the
// result of every other operation are registered in ST_DONE; a new transfer is taken
// only in ST_IDLE, once that result has been registered.
// Reset clears all voices and slots at once; the sample memory is not cleared.
// A result that waits under stall holds the next result back, not the next transfer.
module round_robin_sample_voice_mixer_core import rrsvm_pkg::*; #(
  parameter int unsigned HOLD_TICKS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_addr_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          op_i,
  input  logic [4:0]          sample_id_i,
  input  logic [2:0]          voice_id_i,
  input  logic [15:0]         slot_base_i,
  input  logic [16:0]         slot_length_i,
  input  logic [7:0]          slot_gain_i,
  input  logic                slot_loop_i,
  input  logic [15:0]         byte_address_i,
  input  logic [7:0]          byte_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  audio_out_o,
  output logic [2:0]          voice_taken_o,
  output logic [3:0]          stopped_count_o,
  output logic [3:0]          active_count_o,
  output logic                status_o
);

  localparam int unsigned PhW = (HOLD_TICKS > 1) ? $clog2(HOLD_TICKS) : 1;
  localparam logic [PhW:0] HoldLast = (PhW+1)'(HOLD_TICKS);

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_TRIG  = 3'd1;
  localparam logic [2:0] OP_STOPV = 3'd2;
  localparam logic [2:0] OP_STOPS = 3'd3;
  localparam logic [2:0] OP_WSLOT = 3'd4;
  localparam logic [2:0] OP_WBYTE = 3'd5;

  localparam logic [0:0] CFG_VOLUME = 1'b0;
  localparam logic [0:0] CFG_MUTE   = 1'b1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_VCHK   = 3'd2;
  localparam logic [2:0] ST_VMEM   = 3'd3;
  localparam logic [2:0] ST_VWAIT  = 3'd4;
  localparam logic [2:0] ST_MSTART = 3'd5;
  localparam logic [2:0] ST_MWAIT  = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0] state_q;

  // Captured item.
  logic [2:0]        op_q;
  logic [SLOT_W-1:0] sid_q;
  logic [VOICE_W-1:0] vid_q;
  logic [ADDR_W-1:0] base_q;
  logic [LEN_W-1:0]  len_q;
  logic [7:0]        gain_q;
  logic              loop_q;
  logic [ADDR_W-1:0] baddr_q;
  logic [7:0]        bval_q;

  // Voice and slot tables.
  logic [VOICES-1:0] vact_q;
  logic [SLOT_W-1:0] vslot_q  [VOICES];
  logic [ADDR_W-1:0] vpos_q   [VOICES];
  logic [PhW-1:0]    vphase_q [VOICES];
  logic [VOICE_W-1:0] rr_q;
  logic [ADDR_W-1:0] sstart_q [SLOTS];
  logic [LEN_W-1:0]  ssize_q  [SLOTS];
  logic [7:0]        slevel_q [SLOTS];
  logic [SLOTS-1:0]  srep_q;

  logic [7:0] vol_q;
  logic       mute_q;

  logic [7:0] mem [2**ADDR_W];
  logic [7:0] rdata_q;

  logic [VOICE_W-1:0]      vc_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    neg_q;

  logic signed [15:0] res_audio_q;
  logic [2:0]         res_taken_q;
  logic [3:0]         res_stopped_q;
  logic               res_status_q;

  logic               out_valid_q;
  logic signed [15:0] out_audio_q;
  logic [2:0]         out_taken_q;
  logic [3:0]         out_stopped_q;
  logic [3:0]         out_active_q;
  logic               out_status_q;

  scl_req_t scl_req;
  scl_rsp_t scl_rsp;

  rrsvm_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scl_req),
    .rsp_o  (scl_rsp)
  );

  // Current voice and its slot.
  logic [SLOT_W-1:0] cur_slot;
  logic [ADDR_W-1:0] cur_pos;
  logic [PhW-1:0]    cur_phase;
  logic [LEN_W-1:0]  cur_size;
  logic              cur_bad;
  logic [PhW:0]      phase_inc;
  logic [LEN_W-1:0]  pos_next;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        smag;

  assign cur_slot  = vslot_q[vc_q];
  assign cur_pos   = vpos_q[vc_q];
  assign cur_phase = vphase_q[vc_q];
  assign cur_size  = ssize_q[cur_slot];
  assign cur_bad   = ({1'b0, cur_phase} >= HoldLast) || (cur_size == '0)
                     || ({1'b0, cur_pos} >= cur_size);
  assign phase_inc = {1'b0, cur_phase} + (PhW+1)'(1);
  assign pos_next  = {1'b0, cur_pos} + LEN_W'(1);
  assign raddr     = sstart_q[cur_slot] + cur_pos;
  assign smag      = rdata_q[7] ? {1'b0, rdata_q[6:0]} : 8'd128 - rdata_q;

  // Trigger: first free voice from the pointer onward, else the voice at the pointer.
  logic [VOICE_W-1:0] trig_sel;
  logic               trig_found;
  always_comb begin
    logic [VOICE_W-1:0] c;
    trig_sel   = rr_q;
    trig_found = 1'b0;
    for (int k = 0; k < VOICES; k++) begin
      c = rr_q + VOICE_W'(k);
      if (!trig_found && !vact_q[c]) begin
        trig_sel   = c;
        trig_found = 1'b1;
      end
    end
  end

  logic [VOICES-1:0] stop_hit;
  logic [CNT_W-1:0]  stop_cnt;
  logic [CNT_W-1:0]  act_cnt;
  always_comb begin
    stop_cnt = '0;
    act_cnt  = '0;
    for (int v = 0; v < VOICES; v++) begin
      stop_hit[v] = vact_q[v] && (vslot_q[v] == sid_q);
      stop_cnt    = stop_cnt + CNT_W'(stop_hit[v]);
      act_cnt     = act_cnt + CNT_W'(vact_q[v]);
    end
  end

  logic [SUM_W-1:0] sum_mag;
  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  always_comb begin
    scl_req.start = 1'b0;
    scl_req.a     = SCL_A_W'({smag, 8'b0});
    scl_req.b     = slevel_q[cur_slot];
    if (state_q == ST_VMEM) begin
      scl_req.start = 1'b1;
    end else if (state_q == ST_MSTART && !mute_q) begin
      scl_req.start = 1'b1;
      scl_req.a     = SCL_A_W'(sum_mag);
      scl_req.b     = vol_q;
    end
  end

  logic signed [15:0] mix_sat;
  always_comb begin
    if (neg_q) begin
      mix_sat = (scl_rsp.q > SCL_Q_W'(32768)) ? -16'sd32768 : 16'(-scl_rsp.q);
    end else begin
      mix_sat = (scl_rsp.q > SCL_Q_W'(32767)) ? 16'sd32767 : 16'(scl_rsp.q);
    end
  end

  logic in_xfer, out_free;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= op_i;
      sid_q   <= sample_id_i;
      vid_q   <= voice_id_i;
      base_q  <= slot_base_i;
      len_q   <= slot_length_i;
      gain_q  <= slot_gain_i;
      loop_q  <= slot_loop_i;
      baddr_q <= byte_address_i;
      bval_q  <= byte_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC && op_q == OP_WBYTE) begin
      mem[baddr_q] <= bval_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      vact_q        <= '0;
      rr_q          <= '0;
      srep_q        <= '0;
      vol_q         <= VOLUME_FULL;
      mute_q        <= 1'b0;
      vc_q          <= '0;
      sum_q         <= '0;
      neg_q         <= 1'b0;
      res_audio_q   <= '0;
      res_taken_q   <= '0;
      res_stopped_q <= '0;
      res_status_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      out_audio_q   <= '0;
      out_taken_q   <= '0;
      out_stopped_q <= '0;
      out_active_q  <= '0;
      out_status_q  <= 1'b0;
      for (int v = 0; v < VOICES; v++) begin
        vslot_q[v]  <= '0;
        vpos_q[v]   <= '0;
        vphase_q[v] <= '0;
      end
      for (int s = 0; s < SLOTS; s++) begin
        sstart_q[s] <= '0;
        ssize_q[s]  <= '0;
        slevel_q[s] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_VOLUME: vol_q <= (cfg_wdata_i > VOLUME_FULL) ? VOLUME_FULL : cfg_wdata_i;
          CFG_MUTE:   mute_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            state_q <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          res_audio_q   <= '0;
          res_taken_q   <= '0;
          res_stopped_q <= '0;
          res_status_q  <= 1'b0;
          state_q       <= ST_DONE;
          unique case (op_q)
            OP_TICK: begin
              sum_q   <= '0;
              vc_q    <= '0;
              state_q <= ST_VCHK;
            end
            OP_TRIG: begin
              if (ssize_q[sid_q] == '0) begin
                res_status_q <= 1'b1;
              end else begin
                vact_q[trig_sel]   <= 1'b1;
                vslot_q[trig_sel]  <= sid_q;
                vpos_q[trig_sel]   <= '0;
                vphase_q[trig_sel] <= '0;
                rr_q               <= trig_sel + VOICE_W'(1);
                res_taken_q        <= trig_sel;
              end
            end
            OP_STOPV: begin
              if (!vact_q[vid_q]) begin
                res_status_q <= 1'b1;
              end else begin
                vact_q[vid_q]   <= 1'b0;
                vslot_q[vid_q]  <= '0;
                vpos_q[vid_q]   <= '0;
                vphase_q[vid_q] <= '0;
              end
            end
            OP_STOPS, OP_WSLOT: begin
              if (op_q == OP_WSLOT && len_q > MAX_LENGTH) begin
                res_status_q <= 1'b1;
              end else begin
                res_stopped_q <= stop_cnt;
                for (int v = 0; v < VOICES; v++) begin
                  if (stop_hit[v]) begin
                    vact_q[v]   <= 1'b0;
                    vslot_q[v]  <= '0;
                    vpos_q[v]   <= '0;
                    vphase_q[v] <= '0;
                  end
                end
                if (op_q == OP_WSLOT) begin
                  // A zero length unloads the slot and clears every field.
                  if (len_q == '0) begin
                    sstart_q[sid_q] <= '0;
                    slevel_q[sid_q] <= '0;
                    srep_q[sid_q]   <= 1'b0;
                  end else begin
                    sstart_q[sid_q] <= base_q;
                    slevel_q[sid_q] <= gain_q;
                    srep_q[sid_q]   <= loop_q;
                  end
                  ssize_q[sid_q] <= len_q;
                end
              end
            end
            OP_WBYTE: ;
            default: res_status_q <= 1'b1;
          endcase
        end

        ST_VCHK: begin
          if (vact_q[vc_q] && !cur_bad) begin
            state_q <= ST_VMEM;
          end else begin
            if (vact_q[vc_q]) begin
              vact_q[vc_q]   <= 1'b0;
              vslot_q[vc_q]  <= '0;
              vpos_q[vc_q]   <= '0;
              vphase_q[vc_q] <= '0;
            end
            vc_q    <= vc_q + VOICE_W'(1);
            state_q <= (vc_q == VOICE_W'(VOICES-1)) ? ST_MSTART : ST_VCHK;
          end
        end

        ST_VMEM: begin
          // The byte is already read, so the voice can advance while it is scaled.
          neg_q   <= !rdata_q[7];
          state_q <= ST_VWAIT;
          if (phase_inc == HoldLast) begin
            vphase_q[vc_q] <= '0;
            if (pos_next == cur_size) begin
              if (srep_q[cur_slot]) begin
                vpos_q[vc_q] <= '0;
              end else begin
                vact_q[vc_q]  <= 1'b0;
                vslot_q[vc_q] <= '0;
                vpos_q[vc_q]  <= '0;
              end
            end else begin
              vpos_q[vc_q] <= pos_next[ADDR_W-1:0];
            end
          end else begin
            vphase_q[vc_q] <= phase_inc[PhW-1:0];
          end
        end

        ST_VWAIT: begin
          if (scl_rsp.done) begin
            if (neg_q) begin
              sum_q <= sum_q - $signed(scl_rsp.q[SUM_W-1:0]);
            end else begin
              sum_q <= sum_q + $signed(scl_rsp.q[SUM_W-1:0]);
            end
            vc_q    <= vc_q + VOICE_W'(1);
            state_q <= (vc_q == VOICE_W'(VOICES-1)) ? ST_MSTART : ST_VCHK;
          end
        end

        ST_MSTART: begin
          neg_q <= sum_q[SUM_W-1];
          if (mute_q) begin
            res_audio_q <= '0;
            state_q     <= ST_DONE;
          end else begin
            state_q <= ST_MWAIT;
          end
        end

        ST_MWAIT: begin
          if (scl_rsp.done) begin
            res_audio_q <= mix_sat;
            state_q     <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_audio_q   <= res_audio_q;
            out_taken_q   <= res_taken_q;
            out_stopped_q <= res_stopped_q;
            out_active_q  <= act_cnt;
            out_status_q  <= res_status_q;
            state_q       <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign audio_out_o     = out_audio_q;
  assign voice_taken_o   = out_taken_q;
  assign stopped_count_o = out_stopped_q;
  assign active_count_o  = out_active_q;
  assign status_o        = out_status_q;

endmodule

>>> tb/tb_round_robin_sample_voice_mixer_core.sv
// Self-checking testbench for round_robin_sample_voice_mixer_core.
// A queue-fed driver, a clocked monitor and a built-in predictor of the mixer.
// Depends on rrsvm_pkg and the mixer RTL.
module tb_round_robin_sample_voice_mixer_core;
  import rrsvm_pkg::*;

  localparam int unsigned HOLD = 4;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  typedef enum logic [2:0] {
    OP_TICK = 3'd0, OP_TRIGGER = 3'd1, OP_STOP_VOICE = 3'd2, OP_STOP_SAMPLE = 3'd3,
    OP_WRITE_SLOT = 3'd4, OP_WRITE_BYTE = 3'd5, OP_BAD6 = 3'd6, OP_BAD7 = 3'd7
  } op_e;

  localparam logic [0:0] REG_VOLUME = 1'b0;
  localparam logic [0:0] REG_MUTE   = 1'b1;

  typedef enum logic [1:0] {K_ITEM, K_REG, K_DRAIN} kind_e;

  typedef struct {
    kind_e       kind;
    int unsigned gap;
    logic [2:0]  op;
    logic [4:0]  sid;
    logic [2:0]  vid;
    logic [15:0] base;
    logic [16:0] len;
    logic [7:0]  gain;
    logic        loop_en;
    logic [15:0] baddr;
    logic [7:0]  bval;
    logic [0:0]  reg_idx;
    logic [7:0]  reg_val;
  } cmd_t;

  typedef struct {
    logic signed [15:0] audio;
    logic [2:0]         taken;
    logic [3:0]         stopped;
    logic [3:0]         active;
    logic               status;
  } mix_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_addr_i = '0;
  logic [7:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] op_i = '0;
  logic [4:0] sample_id_i = '0;
  logic [2:0] voice_id_i = '0;
  logic [15:0] slot_base_i = '0;
  logic [16:0] slot_length_i = '0;
  logic [7:0] slot_gain_i = '0;
  logic slot_loop_i = 1'b0;
  logic [15:0] byte_address_i = '0;
  logic [7:0] byte_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] audio_out_o;
  logic [2:0] voice_taken_o;
  logic [3:0] stopped_count_o;
  logic [3:0] active_count_o;
  logic status_o;

  round_robin_sample_voice_mixer_core #(.HOLD_TICKS(HOLD)) DUT (.*);

  always #4 clk_i = ~clk_i;

  // Predictor state.
  logic        v_on [VOICES];
  logic [4:0]  v_slot [VOICES];
  logic [15:0] v_pos [VOICES];
  logic [1:0]  v_phase [VOICES];
  logic [2:0]  rr_ptr;
  logic [15:0] s_start [SLOTS];
  logic [16:0] s_size [SLOTS];
  logic [7:0]  s_gain [SLOTS];
  logic        s_loop [SLOTS];
  logic [7:0]  pcm [int];
  int unsigned master_vol;
  logic        muted;

  cmd_t        pending[$];
  mix_result_t awaited[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;

  task automatic report(input string what);
    errors++;
    $display("ERROR at %0t: %s", $realtime, what);
  endtask

  function automatic void release_voice(int v);
    v_on[v] = 1'b0; v_slot[v] = '0; v_pos[v] = '0; v_phase[v] = '0;
  endfunction

  function automatic int unsigned silence_slot(int s);
    int unsigned n;
    n = 0;
    for (int v = 0; v < VOICES; v++)
      if (v_on[v] && v_slot[v] == s) begin
        release_voice(v);
        n++;
      end
    return n;
  endfunction

  function automatic logic signed [15:0] mix_voices();
    int     sum;
    int     centred;
    int     next_pos;
    int     s;
    longint scaled;
    sum = 0;
    for (int v = 0; v < VOICES; v++) begin
      if (!v_on[v]) continue;
      s = v_slot[v];
      if (s_size[s] == 0 || v_pos[v] >= s_size[s]) begin
        release_voice(v);
        continue;
      end
      centred = int'(pcm[(s_start[s] + v_pos[v]) & 16'hFFFF]) - 128;
      sum += (centred * 256 * int'(s_gain[s])) / 255;
      if (v_phase[v] == HOLD - 1) begin
        v_phase[v] = '0;
        next_pos = v_pos[v] + 1;
        if (next_pos == s_size[s]) begin
          if (s_loop[s]) v_pos[v] = '0;
          else release_voice(v);
        end else begin
          v_pos[v] = next_pos[15:0];
        end
      end else begin
        v_phase[v] = v_phase[v] + 2'd1;
      end
    end
    scaled = muted ? 64'sd0 : (longint'(sum) * longint'(master_vol)) / 64'sd255;
    if (scaled > 32767) scaled = 32767;
    if (scaled < -32768) scaled = -32768;
    return scaled[15:0];
  endfunction

  function automatic mix_result_t mixer_outcome(cmd_t c);
    mix_result_t r;
    int          pick;
    int          n;
    r = '{default: '0};
    case (op_e'(c.op))
      OP_TICK: r.audio = mix_voices();
      OP_TRIGGER: begin
        if (s_size[c.sid] == 0) begin
          r.status = 1'b1;
        end else begin
          pick = rr_ptr;
          for (int k = 0; k < VOICES; k++)
            if (!v_on[(rr_ptr + k) % VOICES]) begin
              pick = (rr_ptr + k) % VOICES;
              break;
            end
          v_on[pick] = 1'b1; v_slot[pick] = c.sid; v_pos[pick] = '0; v_phase[pick] = '0;
          rr_ptr = 3'((pick + 1) % VOICES);
          r.taken = 3'(pick);
        end
      end
      OP_STOP_VOICE: begin
        if (!v_on[c.vid]) r.status = 1'b1;
        else release_voice(c.vid);
      end
      OP_STOP_SAMPLE: r.stopped = 4'(silence_slot(c.sid));
      OP_WRITE_SLOT: begin
        if (c.len == 0) begin
          r.stopped = 4'(silence_slot(c.sid));
          s_start[c.sid] = '0; s_size[c.sid] = '0; s_gain[c.sid] = '0; s_loop[c.sid] = 1'b0;
        end else if (c.len > MAX_LENGTH) begin
          r.status = 1'b1;
        end else begin
          r.stopped = 4'(silence_slot(c.sid));
          s_start[c.sid] = c.base; s_size[c.sid] = c.len;
          s_gain[c.sid] = c.gain; s_loop[c.sid] = c.loop_en;
        end
      end
      OP_WRITE_BYTE: pcm[c.baddr] = c.bval;
      default: r.status = 1'b1;
    endcase
    n = 0;
    for (int v = 0; v < VOICES; v++) if (v_on[v]) n++;
    r.active = 4'(n);
    return r;
  endfunction

  // Driver: presents one queued command at a time after its idle gap.
  int unsigned gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t c;
    logic taken_now;
    logic valid_next;
    logic we_next;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cfg_we_i <= 1'b0;
      gap_left <= 0;
    end else begin
      taken_now = in_valid_i && !in_stall_o;
      valid_next = in_valid_i && !taken_now;
      we_next = 1'b0;
      if (taken_now) awaited.push_back(mixer_outcome(pending.pop_front()));
      if (!valid_next && pending.size() > 0) begin
        c = pending[0];
        if (c.kind == K_ITEM && taken_now) begin
          gap_left <= c.gap;
        end else if (c.kind == K_ITEM && gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (c.kind == K_ITEM) begin
          op_i <= c.op; sample_id_i <= c.sid; voice_id_i <= c.vid;
          slot_base_i <= c.base; slot_length_i <= c.len; slot_gain_i <= c.gain;
          slot_loop_i <= c.loop_en; byte_address_i <= c.baddr; byte_value_i <= c.bval;
          valid_next = 1'b1;
        end else if (awaited.size() == 0 && !taken_now) begin
          // Register writes and pauses wait until every result is back.
          if (c.kind == K_REG) begin
            we_next = 1'b1;
            cfg_addr_i <= c.reg_idx;
            cfg_wdata_i <= c.reg_val;
            if (c.reg_idx == REG_VOLUME) master_vol = c.reg_val;
            else muted = c.reg_val[0];
          end
          void'(pending.pop_front());
        end
      end
      cfg_we_i <= we_next;
      in_valid_i <= valid_next;
    end
  end

  // Monitor: random back-pressure and in-order checking.
  int unsigned stall_left = 0;
  logic        burst_mode = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    mix_result_t e;
    int unsigned n;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      n = stall_left;
      if (out_valid_o && !out_stall_i) begin
        if (awaited.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          e = awaited.pop_front();
          if (audio_out_o !== e.audio)
            report($sformatf("audio_out %0d, expected %0d", audio_out_o, e.audio));
          if (voice_taken_o !== e.taken)
            report($sformatf("voice_taken %0d, expected %0d", voice_taken_o, e.taken));
          if (stopped_count_o !== e.stopped)
            report($sformatf("stopped_count %0d, expected %0d", stopped_count_o, e.stopped));
          if (active_count_o !== e.active)
            report($sformatf("active_count %0d, expected %0d", active_count_o, e.active));
          if (status_o !== e.status)
            report($sformatf("status %0d, expected %0d", status_o, e.status));
        end
        n = burst_mode ? 0 : $urandom_range(0, 7);
      end else if (n > 0) begin
        n--;
      end
      stall_left <= n;
      out_stall_i <= (n != 0);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_round_robin_sample_voice_mixer_core failed");
      $finish;
    end
  end

  function automatic cmd_t blank_cmd(logic [2:0] op);
    cmd_t c;
    c = '{kind: K_ITEM, gap: 0, op: op, sid: '0, vid: '0, base: '0, len: '0, gain: '0,
          loop_en: 1'b0, baddr: '0, bval: '0, reg_idx: '0, reg_val: '0};
    return c;
  endfunction

  task automatic push_op(logic [2:0] op, logic [4:0] sid = 0, logic [2:0] vid = 0);
    cmd_t c;
    c = blank_cmd(op);
    c.sid = sid;
    c.vid = vid;
    pending.push_back(c);
  endtask

  task automatic push_slot(logic [4:0] sid, logic [15:0] base, logic [16:0] len,
                           logic [7:0] gain, logic lp);
    cmd_t c;
    c = blank_cmd(OP_WRITE_SLOT);
    c.sid = sid; c.base = base; c.len = len; c.gain = gain; c.loop_en = lp;
    pending.push_back(c);
  endtask

  task automatic push_byte(logic [15:0] addr, logic [7:0] value);
    cmd_t c;
    c = blank_cmd(OP_WRITE_BYTE);
    c.baddr = addr; c.bval = value;
    pending.push_back(c);
  endtask

  task automatic push_reg(logic [0:0] idx, logic [7:0] value);
    cmd_t c;
    c = blank_cmd(OP_TICK);
    c.kind = K_REG; c.reg_idx = idx; c.reg_val = value;
    pending.push_back(c);
  endtask

  // Voices only ever read a few dozen bytes past their slot start, so slot bases
  // stay inside the preloaded windows at the bottom and top of sample memory.
  function automatic cmd_t random_cmd(logic quiet);
    cmd_t c;
    int unsigned pick;
    c = blank_cmd(3'($urandom_range(0, 7)));
    c.gap = quiet ? 0 : $urandom_range(0, 7);
    c.sid = 5'($urandom); c.vid = 3'($urandom); c.base = 16'($urandom);
    c.len = 17'($urandom); c.gain = 8'($urandom); c.loop_en = 1'($urandom);
    c.baddr = 16'($urandom); c.bval = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) c.op = OP_TICK;
    else if (pick < 60) c.op = OP_TRIGGER;
    else if (pick < 68) c.op = OP_STOP_VOICE;
    else if (pick < 74) c.op = OP_STOP_SAMPLE;
    else if (pick < 86) c.op = OP_WRITE_SLOT;
    else if (pick < 96) c.op = OP_WRITE_BYTE;
    else c.op = $urandom_range(0, 1) ? OP_BAD6 : OP_BAD7;
    if (c.op == OP_WRITE_SLOT) begin
      c.base = $urandom_range(0, 1) ? 16'($urandom_range(0, 63))
                                    : 16'($urandom_range(65472, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 70) c.len = 17'($urandom_range(1, 16));
      else if (pick < 85) c.len = 17'($urandom_range(17, 65536));
      else if (pick < 90) c.len = '0;
      else c.len = 17'($urandom_range(65537, 131071));
    end
    return c;
  endfunction

  initial begin
    cmd_t c;
    logic quiet;
    for (int v = 0; v < VOICES; v++) release_voice(v);
    for (int s = 0; s < SLOTS; s++) begin
      s_start[s] = '0; s_size[s] = '0; s_gain[s] = '0; s_loop[s] = 1'b0;
    end
    rr_ptr = '0;
    master_vol = 255;
    muted = 1'b0;

    // Preload both windows of sample memory.
    for (int a = 0; a < 192; a++) push_byte(16'(a), 8'($urandom));
    for (int a = 65472; a < 65536; a++) push_byte(16'(a), 8'($urandom));

    // Directed part.
    push_byte(16'd700, 8'hFF);
    push_byte(16'd701, 8'h00);
    push_slot(5'd2, 16'd700, 17'd1, 8'd255, 1'b1);
    push_slot(5'd3, 16'd701, 17'd1, 8'd255, 1'b1);
    push_op(OP_TRIGGER, 5'd9);
    for (int k = 0; k < 9; k++) push_op(OP_TRIGGER, 5'd2);
    push_op(OP_TICK);
    push_op(OP_STOP_SAMPLE, 5'd2);
    push_slot(5'd3, 16'd701, 17'd1, 8'd255, 1'b1);
    for (int k = 0; k < 8; k++) push_op(OP_TRIGGER, 5'd3);
    push_op(OP_TICK);
    push_slot(5'd3, 16'd0, 17'd0, 8'd0, 1'b0);
    push_op(OP_STOP_VOICE, 5'd0, 3'd7);
    push_slot(5'd31, 16'hFFFF, 17'd2, 8'd0, 1'b0);
    push_slot(5'd1, 16'd0, MAX_LENGTH, 8'd128, 1'b0);
    push_slot(5'd0, 16'd0, 17'h1FFFF, 8'd10, 1'b0);
    push_op(OP_TRIGGER, 5'd31);
    push_op(OP_TRIGGER, 5'd1);
    for (int k = 0; k < 9; k++) push_op(OP_TICK);
    push_op(OP_BAD6);
    push_op(OP_BAD7);

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin push_reg(REG_VOLUME, 8'd255); push_reg(REG_MUTE, 8'd0); end
        1: push_reg(REG_VOLUME, 8'd0);
        2: push_reg(REG_VOLUME, 8'd1);
        3: begin push_reg(REG_VOLUME, 8'($urandom)); push_reg(REG_MUTE, 8'd1); end
        4: begin push_reg(REG_VOLUME, 8'd200); push_reg(REG_MUTE, 8'd0); end
        default: push_reg(REG_VOLUME, 8'($urandom));
      endcase
      quiet = (ph % 3 == 1);
      for (int k = 0; k < 100; k++) begin
        if (k == 50) begin
          c = blank_cmd(OP_TICK);
          c.kind = K_DRAIN;
          pending.push_back(c);
        end
        pending.push_back(random_cmd(quiet));
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    burst_mode = 1'b0;

    while (pending.size() > 0 || in_valid_i || awaited.size() > 0) begin
      @(posedge clk_i);
      // Switch back-pressure style by how many commands are still pending.
      burst_mode = (pending.size() % 400) < 60;
    end
    repeat (80) @(posedge clk_i);
    if (errors == 0 && awaited.size() == 0) begin
      $display("tb_round_robin_sample_voice_mixer_core passed");
    end else begin
      $display("tb_round_robin_sample_voice_mixer_core failed");
    end
    $finish;
  end

endmodule
